// ===== hw/rtl/kernel_convolution_2d_assert.svh =====
// Assertion macros for the kernel convolution block.
// Every macro is clocked on clk and disabled while rst is high.
`ifndef KERNEL_CONVOLUTION_2D_ASSERT_SVH
`define KERNEL_CONVOLUTION_2D_ASSERT_SVH

// Same-cycle implication.
`define KC2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KC2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/kc2d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package kc2d_pkg;

  localparam int MAX_TAPS_SIDE_DEF = 9;
  localparam int MAX_LINE_DEF      = 1024;

  localparam int TYPE_W     = 2;
  localparam int TAP_IDX_W  = 7;
  localparam int COEF_W     = 16;
  localparam int PIX_W      = 16;
  localparam int RES_W      = 18;
  localparam int COL_OUT_W  = 10;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int PROD_W     = COEF_W + PIX_W + 1;
  localparam int ACC_W      = 40;

  // request codes
  localparam logic [TYPE_W-1:0] REQ_COEF  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_PIXEL = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_DRAIN = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_REPLICATE = 3'd4;

  // register reset values
  localparam logic [3:0]  KERNEL_COLS_RST = 4'd3;
  localparam logic [3:0]  KERNEL_ROWS_RST = 4'd3;
  localparam logic [10:0] FRAME_COLS_RST  = 11'd640;
  localparam logic [11:0] FRAME_ROWS_RST  = 12'd480;
  localparam logic        EDGE_REP_RST    = 1'b1;

  localparam logic signed [ACC_W-12:0] SAT_HI = 29'sd131071;
  localparam logic signed [ACC_W-12:0] SAT_LO = -29'sd131072;

  // control from the sequencer to the MAC datapath
  typedef struct packed {
    logic clear;
    logic valid;
    logic use_tap;
  } mac_ctl_t;

  // round to Q1.16 (ties up) and saturate to the result range
  function automatic logic signed [RES_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0]    biased;
    logic signed [ACC_W-12:0] shifted;
    biased  = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W+1)'(2048));
    shifted = biased[ACC_W:12];
    if (shifted > SAT_HI) begin
      return SAT_HI[RES_W-1:0];
    end else if (shifted < SAT_LO) begin
      return SAT_LO[RES_W-1:0];
    end else begin
      return shifted[RES_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/kc2d_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kc2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 81,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/kc2d_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kc2d_mac (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire kc2d_pkg::mac_ctl_t                   ctl,
  input  wire logic signed [kc2d_pkg::COEF_W-1:0]   coef,
  input  wire logic [3*kc2d_pkg::PIX_W-1:0]         pixel,
  output logic signed [kc2d_pkg::RES_W-1:0]         red_res,
  output logic signed [kc2d_pkg::RES_W-1:0]         green_res,
  output logic signed [kc2d_pkg::RES_W-1:0]         blue_res
);

  localparam int PW = kc2d_pkg::PIX_W;

  logic signed [kc2d_pkg::PROD_W-1:0] prod [3];
  logic signed [kc2d_pkg::ACC_W-1:0]  acc  [3];
  logic                               prod_valid;

  // multiply stage: one product per channel
  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (ctl.use_tap) begin
          prod[ch] <= coef * $signed({1'b0, pixel[(2-ch)*PW +: PW]});
        end else begin
          prod[ch] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.valid;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (ctl.clear) begin
        acc[ch] <= '0;
      end else if (prod_valid) begin
        acc[ch] <= acc[ch] + kc2d_pkg::ACC_W'(prod[ch]);
      end
    end
  end

  assign red_res   = kc2d_pkg::round_sat(acc[0]);
  assign green_res = kc2d_pkg::round_sat(acc[1]);
  assign blue_res  = kc2d_pkg::round_sat(acc[2]);

endmodule
`default_nettype wire

// ===== hw/rtl/kernel_convolution_2d.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Streaming 2-D convolution (correlation) of a raster RGB pixel stream.
// Input channel (in_valid/in_ready): req_type selects a coefficient load
// (tap_index, tap_value), a pixel (red_in, green_in, blue_in) or a drain tick.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// kernel size, frame size and border mode; it is always ready, and the user must
// write it only while the block is idle: the block itself does not enforce this.
// Output channel (out_valid/out_ready): one filtered pixel with its column,
// row and a frame_end flag; results trail the input by half a kernel.
// A coefficient load is taken in the idle state. A pixel or drain tick goes
// through a check state and, when an output is due, a row state and KC taps for
// each of KR rows (the effective kernel rows and columns), then a flush and a
// finish state; the taps go one a cycle through the single read port of the line
// memory and the coefficient memory. A finished result waits in the output
// register; the next transaction is taken meanwhile, and only a following result
// stalls until the receiver takes the waiting one.
// Reset clears the counters, the registers to their defaults and the kernel
// to zero (per-tap valid bits); the line memory needs no clearing pass.
module kernel_convolution_2d #(
  parameter int MAX_TAPS_SIDE = kc2d_pkg::MAX_TAPS_SIDE_DEF,
  parameter int MAX_LINE      = kc2d_pkg::MAX_LINE_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [kc2d_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [kc2d_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [kc2d_pkg::TYPE_W-1:0]           req_type,
  input  wire logic [kc2d_pkg::TAP_IDX_W-1:0]        tap_index,
  input  wire logic signed [kc2d_pkg::COEF_W-1:0]    tap_value,
  input  wire logic [kc2d_pkg::PIX_W-1:0]            red_in,
  input  wire logic [kc2d_pkg::PIX_W-1:0]            green_in,
  input  wire logic [kc2d_pkg::PIX_W-1:0]            blue_in,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [kc2d_pkg::RES_W-1:0]          red_out,
  output logic signed [kc2d_pkg::RES_W-1:0]          green_out,
  output logic signed [kc2d_pkg::RES_W-1:0]          blue_out,
  output logic [kc2d_pkg::COL_OUT_W-1:0]             col_out,
  output logic [kc2d_pkg::ROW_W-1:0]                 row_out,
  output logic                                       frame_end
);

  localparam int RING     = MAX_TAPS_SIDE + 1;
  localparam int SW       = $clog2(RING);
  localparam int LW       = $clog2(MAX_LINE);
  localparam int TAPS     = MAX_TAPS_SIDE * MAX_TAPS_SIDE;
  localparam int CAW      = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int HALF_MAX = (MAX_TAPS_SIDE - 1) / 2;
  localparam int HW       = $clog2(HALF_MAX + 1) + 1;
  localparam int TW       = $clog2(MAX_TAPS_SIDE + 1);
  localparam int PW       = kc2d_pkg::PIX_W;
  localparam int RW       = kc2d_pkg::ROW_W;
  localparam int MOD_SH   = 24;
  localparam int MOD_M    = (1 << MOD_SH) / RING;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ROW   = 3'd2;
  localparam logic [2:0] S_TAP   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  // row to ring slot: reciprocal multiply and one correction
  function automatic logic [SW-1:0] ring_slot(input logic [RW-1:0] row);
    logic [35:0] prod;
    logic [RW-1:0] quo;
    logic [15:0] rem;
    prod = 36'(row) * 36'(MOD_M);
    quo  = prod[MOD_SH +: RW];
    rem  = 16'(row) - 16'(quo) * 16'(RING);
    if (rem >= 16'(RING)) begin
      rem = rem - 16'(RING);
    end
    return rem[SW-1:0];
  endfunction

  // configuration registers
  logic [3:0]  kernel_cols, kernel_rows;
  logic [10:0] frame_cols;
  logic [11:0] frame_rows;
  logic        edge_replicate;

  // sequencer state
  logic [2:0]    state;
  logic [LW-1:0] in_col, emit_col;
  logic [RW-1:0] in_row, emit_row;
  logic [TW-1:0] dy_i, dx_i;
  logic [SW-1:0] row_slot;
  logic          row_skip;
  logic          flush_cnt;
  logic [TAPS-1:0] coef_vld;
  logic          coef_vld_rd;
  logic          iss_valid, iss_use;

  // derived sizes
  logic [LW:0]    c_eff;
  logic [RW-1:0]  r_eff;
  logic [HW-1:0]  hx, hy;
  logic [RW:0]    nr;
  logic [LW+1:0]  nc;
  logic           out_due;
  logic signed [14:0] yr_s, xc_s;
  logic [RW-1:0]  yr_cl;
  logic [LW-1:0]  xc_cl;
  logic           y_oob, x_oob;
  logic           row_last, col_last;
  logic           accept, pix_store;
  logic [LW:0]    in_col_inc, emit_col_inc;
  logic [RW-1:0]  emit_row_inc;
  logic           emit_last;
  logic           out_free;

  // memory ports
  logic                 line_we, line_re, coef_we, coef_re;
  logic [SW+LW-1:0]     line_waddr, line_raddr;
  logic [3*PW-1:0]      line_rdata;
  logic [CAW-1:0]       coef_waddr, coef_raddr;
  logic [kc2d_pkg::COEF_W-1:0] coef_rdata;
  logic [7:0]           tap_ext;
  logic signed [kc2d_pkg::COEF_W-1:0] coef_eff;
  kc2d_pkg::mac_ctl_t   mac_ctl;
  logic signed [kc2d_pkg::RES_W-1:0] red_res, green_res, blue_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // effective frame and kernel sizes
  always_comb begin
    if (32'(frame_cols) > MAX_LINE) begin
      c_eff = (LW+1)'(MAX_LINE);
    end else if (frame_cols == 11'd0) begin
      c_eff = (LW+1)'(1);
    end else begin
      c_eff = (LW+1)'(frame_cols);
    end
    r_eff = (frame_rows == 12'd0) ? 12'd1 : frame_rows;
    hx = (32'(kernel_cols[3:1]) > HALF_MAX) ? HW'(HALF_MAX) : HW'(kernel_cols[3:1]);
    hy = (32'(kernel_rows[3:1]) > HALF_MAX) ? HW'(HALF_MAX) : HW'(kernel_rows[3:1]);
  end

  // readiness of the next output
  always_comb begin
    nr = (RW+1)'(emit_row) + (RW+1)'(hy);
    if (nr > (RW+1)'(r_eff - 12'd1)) begin
      nr = (RW+1)'(r_eff - 12'd1);
    end
    nc = (LW+2)'(emit_col) + (LW+2)'(hx);
    if (nc > (LW+2)'(c_eff - 1'b1)) begin
      nc = (LW+2)'(c_eff - 1'b1);
    end
    out_due = (nr < (RW+1)'(in_row)) ||
              ((nr == (RW+1)'(in_row)) && (nc < (LW+2)'(in_col)));
  end

  // window position of the current tap with border clamp
  always_comb begin
    yr_s  = $signed(15'(emit_row)) + $signed(15'(dy_i)) - $signed(15'(hy));
    y_oob = (yr_s < 0) || (yr_s >= $signed(15'(r_eff)));
    if (yr_s < 0) begin
      yr_cl = '0;
    end else if (y_oob) begin
      yr_cl = r_eff - 12'd1;
    end else begin
      yr_cl = yr_s[RW-1:0];
    end
    xc_s  = $signed(15'(emit_col)) + $signed(15'(dx_i)) - $signed(15'(hx));
    x_oob = (xc_s < 0) || (xc_s >= $signed(15'(c_eff)));
    if (xc_s < 0) begin
      xc_cl = '0;
    end else if (x_oob) begin
      xc_cl = LW'(c_eff - 1'b1);
    end else begin
      xc_cl = xc_s[LW-1:0];
    end
    row_last = (8'(dy_i) == 8'(2 * 32'(hy)));
    col_last = (8'(dx_i) == 8'(2 * 32'(hx)));
  end

  // counter increments
  always_comb begin
    in_col_inc   = (LW+1)'(in_col) + 1'b1;
    emit_col_inc = (LW+1)'(emit_col) + 1'b1;
    emit_row_inc = emit_row;
    if (emit_col_inc >= c_eff) begin
      emit_col_inc = '0;
      emit_row_inc = emit_row + 12'd1;
    end
    emit_last = ((RW+1)'(emit_row_inc) >= (RW+1)'(r_eff)) ||
                ((emit_col_inc == '0) && (emit_row == r_eff - 12'd1));
  end

  // memory port control
  assign pix_store  = accept && (req_type == kc2d_pkg::REQ_PIXEL) && (in_row < r_eff) &&
                      (32'(in_col) < MAX_LINE);
  assign line_we    = pix_store;
  assign line_waddr = {ring_slot(in_row), in_col};
  assign line_re    = (state == S_TAP);
  assign line_raddr = {row_slot, xc_cl};
  assign tap_ext    = 8'(tap_index);
  assign coef_we    = accept && (req_type == kc2d_pkg::REQ_COEF) && (32'(tap_index) < TAPS);
  assign coef_waddr = tap_ext[CAW-1:0];
  assign coef_re    = (state == S_TAP);
  assign coef_raddr = CAW'(32'(dy_i) * MAX_TAPS_SIDE + 32'(dx_i));
  assign coef_eff   = coef_vld_rd ? $signed(coef_rdata) : '0;

  assign mac_ctl.clear   = (state == S_CHECK);
  assign mac_ctl.valid   = iss_valid;
  assign mac_ctl.use_tap = iss_use;

  kc2d_ram #(
    .WIDTH (3 * PW),
    .DEPTH (RING << LW),
    .AW    (SW + LW)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata ({red_in, green_in, blue_in}),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  kc2d_ram #(
    .WIDTH (kc2d_pkg::COEF_W),
    .DEPTH (TAPS),
    .AW    (CAW)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (tap_value),
    .re    (coef_re),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  kc2d_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .coef      (coef_eff),
    .pixel     (line_rdata),
    .red_res   (red_res),
    .green_res (green_res),
    .blue_res  (blue_res)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_cols    <= kc2d_pkg::KERNEL_COLS_RST;
      kernel_rows    <= kc2d_pkg::KERNEL_ROWS_RST;
      frame_cols     <= kc2d_pkg::FRAME_COLS_RST;
      frame_rows     <= kc2d_pkg::FRAME_ROWS_RST;
      edge_replicate <= kc2d_pkg::EDGE_REP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kc2d_pkg::REG_KERNEL_COLS:    kernel_cols    <= cfg_data[3:0];
        kc2d_pkg::REG_KERNEL_ROWS:    kernel_rows    <= cfg_data[3:0];
        kc2d_pkg::REG_FRAME_COLS:     frame_cols     <= cfg_data[10:0];
        kc2d_pkg::REG_FRAME_ROWS:     frame_rows     <= cfg_data[11:0];
        kc2d_pkg::REG_EDGE_REPLICATE: edge_replicate <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // kernel tap valid bits: an unwritten tap reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
    end else if (coef_we) begin
      coef_vld[coef_waddr] <= 1'b1;
    end
  end

  // issue flags travel alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_valid <= 1'b0;
    end else begin
      iss_valid <= (state == S_TAP);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_TAP) begin
      iss_use     <= !(row_skip || (x_oob && !edge_replicate));
      coef_vld_rd <= coef_vld[coef_raddr];
    end
  end

  // sequencer and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_col    <= '0;
      in_row    <= '0;
      emit_col  <= '0;
      emit_row  <= '0;
      dy_i      <= '0;
      dx_i      <= '0;
      flush_cnt <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req_type == kc2d_pkg::REQ_PIXEL) begin
              if (in_row < r_eff) begin
                if (in_col_inc >= c_eff) begin
                  in_col <= '0;
                  in_row <= in_row + 12'd1;
                end else begin
                  in_col <= in_col_inc[LW-1:0];
                end
              end
              state <= S_CHECK;
            end else if (req_type == kc2d_pkg::REQ_DRAIN) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          dy_i  <= '0;
          dx_i  <= '0;
          state <= out_due ? S_ROW : S_IDLE;
        end
        S_ROW: begin
          state <= S_TAP;
        end
        S_TAP: begin
          if (col_last) begin
            dx_i <= '0;
            if (row_last) begin
              flush_cnt <= 1'b0;
              state     <= S_FLUSH;
            end else begin
              dy_i  <= dy_i + 1'b1;
              state <= S_ROW;
            end
          end else begin
            dx_i <= dx_i + 1'b1;
          end
        end
        S_FLUSH: begin
          flush_cnt <= 1'b1;
          if (flush_cnt) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (emit_last) begin
              emit_col <= '0;
              emit_row <= '0;
              in_col   <= '0;
              in_row   <= '0;
            end else begin
              emit_col <= emit_col_inc[LW-1:0];
              emit_row <= emit_row_inc;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ring slot and skip flag of the current kernel row
  always_ff @(posedge clk) begin
    if (state == S_ROW) begin
      row_slot <= ring_slot(yr_cl);
      row_skip <= y_oob && !edge_replicate;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      red_out   <= red_res;
      green_out <= green_res;
      blue_out  <= blue_res;
      col_out   <= kc2d_pkg::COL_OUT_W'(emit_col);
      row_out   <= emit_row;
      frame_end <= emit_last;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/kc2d_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "kernel_convolution_2d_assert.svh"
module kc2d_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic [kc2d_pkg::TYPE_W-1:0]         req_type,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [kc2d_pkg::RES_W-1:0]   red_out,
  input wire logic signed [kc2d_pkg::RES_W-1:0]   green_out,
  input wire logic signed [kc2d_pkg::RES_W-1:0]   blue_out,
  input wire logic [kc2d_pkg::COL_OUT_W-1:0]      col_out,
  input wire logic [kc2d_pkg::ROW_W-1:0]          row_out,
  input wire logic                                frame_end
);

  // a stalled result is held
  `KC2D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // a stalled result keeps its payload
  `KC2D_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({red_out, green_out, blue_out, col_out, row_out, frame_end}), "result changed while stalled")

  // the output register comes out of reset empty
  `KC2D_ASSERT_NOW(a_reset_empty, $fell(rst), !out_valid, "result present after reset")

  // a coefficient load never raises a result
  `KC2D_ASSERT_NEXT(a_coef_silent, in_valid && in_ready && req_type == kc2d_pkg::REQ_COEF, !$rose(out_valid), "coefficient load produced a result")

  // a pixel transaction always occupies the sequencer for its check
  `KC2D_ASSERT_NEXT(a_pixel_busy, in_valid && in_ready && req_type == kc2d_pkg::REQ_PIXEL, !in_ready, "pixel transaction skipped its output check")

endmodule

bind kernel_convolution_2d kc2d_checker u_kc2d_checker (.*);
`default_nettype wire
